@@ hw/rtl/bpc_pkg.sv @@
package bpc_pkg;

	typedef struct packed {
		logic [23:0] raw_temperature;
		logic [23:0] raw_pressure;
	} bpc_in_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic signed [31:0] pressure_pa;
		logic signed [31:0] altitude_mm;
	} bpc_out_t;

	typedef enum logic [2:0] {
		CFG_CAL_LOW  = 3'd0,
		CFG_CAL_MID  = 3'd1,
		CFG_CAL_HIGH = 3'd2,
		CFG_FSEL     = 3'd3,
		CFG_VERSION  = 3'd4,
		CFG_CORR_EN  = 3'd5
	} bpc_cfg_idx_t;

	localparam logic signed [31:0] RAW_OFFSET   = 32'sd8388608;
	localparam logic signed [31:0] T_BASE       = 32'sd81920000;
	localparam logic signed [31:0] CF_BASE      = 32'sd2097152;
	localparam logic signed [31:0] P_BASE       = 32'sd99880;
	localparam logic signed [31:0] K1_TWO       = 32'sd4459;
	localparam logic signed [31:0] K4_TWO       = 32'sd120586;
	localparam logic signed [31:0] K5_TWO       = 32'sd4443;
	localparam logic signed [31:0] K7_TWO       = 32'sd166426;
	localparam logic signed [31:0] K8_TWO       = 32'sd7180;
	localparam logic signed [31:0] K1_ONE       = 32'sd4418;
	localparam logic signed [31:0] K4_ONE       = 32'sd211288;
	localparam logic signed [31:0] K7_ONE       = 32'sd285594;
	localparam logic signed [31:0] K8_ONE       = 32'sd7209;
	localparam logic [4:0]         VERSION_CORR = 5'd3;
	localparam logic [31:0]        LOW_MASK     = 32'h7FF;

	// Altitude segments, highest pressure first; the last one catches everything below.
	function automatic logic signed [31:0] seg_thr(input logic [3:0] i);
		logic signed [31:0] r;
		unique case (i)
			4'd0:  r = 32'sd103000;
			4'd1:  r = 32'sd98000;
			4'd2:  r = 32'sd93000;
			4'd3:  r = 32'sd88000;
			4'd4:  r = 32'sd83000;
			4'd5:  r = 32'sd78000;
			4'd6:  r = 32'sd73000;
			4'd7:  r = 32'sd68000;
			4'd8:  r = 32'sd63000;
			4'd9:  r = 32'sd58000;
			4'd10: r = 32'sd53000;
			4'd11: r = 32'sd48000;
			4'd12: r = 32'sd43000;
			4'd13: r = 32'sd38000;
			4'd14: r = 32'sd33000;
			default: r = 32'sh8000_0000;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] seg_base(input logic [3:0] i);
		logic signed [31:0] r;
		unique case (i)
			4'd0:  r = 32'sd103000;
			4'd1:  r = 32'sd98000;
			4'd2:  r = 32'sd93000;
			4'd3:  r = 32'sd88000;
			4'd4:  r = 32'sd83000;
			4'd5:  r = 32'sd78000;
			4'd6:  r = 32'sd73000;
			4'd7:  r = 32'sd68000;
			4'd8:  r = 32'sd63000;
			4'd9:  r = 32'sd58000;
			4'd10: r = 32'sd53000;
			4'd11: r = 32'sd48000;
			4'd12: r = 32'sd43000;
			4'd13: r = 32'sd38000;
			4'd14: r = 32'sd33000;
			default: r = 32'sd28000;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] seg_h0(input logic [3:0] i);
		logic signed [31:0] r;
		unique case (i)
			4'd0:  r = -32'sd138507;
			4'd1:  r = 32'sd280531;
			4'd2:  r = 32'sd717253;
			4'd3:  r = 32'sd1173421;
			4'd4:  r = 32'sd1651084;
			4'd5:  r = 32'sd2152645;
			4'd6:  r = 32'sd2680954;
			4'd7:  r = 32'sd3239426;
			4'd8:  r = 32'sd3832204;
			4'd9:  r = 32'sd4464387;
			4'd10: r = 32'sd5142359;
			4'd11: r = 32'sd5874268;
			4'd12: r = 32'sd6670762;
			4'd13: r = 32'sd7546157;
			4'd14: r = 32'sd8520395;
			default: r = 32'sd9622536;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] seg_hs0(input logic [3:0] i);
		logic signed [31:0] r;
		unique case (i)
			4'd0:  r = -32'sd21007;
			4'd1:  r = -32'sd21869;
			4'd2:  r = -32'sd22813;
			4'd3:  r = -32'sd23854;
			4'd4:  r = -32'sd25007;
			4'd5:  r = -32'sd26292;
			4'd6:  r = -32'sd27735;
			4'd7:  r = -32'sd29366;
			4'd8:  r = -32'sd31229;
			4'd9:  r = -32'sd33377;
			4'd10: r = -32'sd35885;
			4'd11: r = -32'sd38855;
			4'd12: r = -32'sd42434;
			4'd13: r = -32'sd46841;
			4'd14: r = -32'sd52412;
			default: r = -32'sd59704;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] seg_hs1(input logic [3:0] i);
		logic signed [31:0] r;
		unique case (i)
			4'd0:  r = 32'sd311;
			4'd1:  r = 32'sd338;
			4'd2:  r = 32'sd370;
			4'd3:  r = 32'sd407;
			4'd4:  r = 32'sd450;
			4'd5:  r = 32'sd501;
			4'd6:  r = 32'sd560;
			4'd7:  r = 32'sd632;
			4'd8:  r = 32'sd719;
			4'd9:  r = 32'sd826;
			4'd10: r = 32'sd960;
			4'd11: r = 32'sd1131;
			4'd12: r = 32'sd1354;
			4'd13: r = 32'sd1654;
			4'd14: r = 32'sd2072;
			default: r = 32'sd2682;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/baro_pressure_temp_compensation_top.sv @@
// Each accepted input word is carried through the registered stages to its result word at the output.
// Throughput: one word per cycle; the whole pipeline holds while the output word waits.
// The depth is set by the chain of dependent 32-bit multiplies in the pressure polynomial.
// Reset clears all stage valid bits and returns the configuration to its reset values.
module baro_pressure_temp_compensation_top
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  bpc_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output bpc_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] cal_lo_q, cal_mid_q;
	logic [31:0] cal_hi_q;
	logic [7:0]  fsel_q;
	logic [4:0]  ver_q;
	logic [1:0]  cen_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_lo_q  <= '0;
			cal_mid_q <= '0;
			cal_hi_q  <= '0;
			fsel_q    <= 8'd1;
			ver_q     <= '0;
			cen_q     <= 2'd3;
		end else if (cfg_valid) begin
			unique case (bpc_cfg_idx_t'(cfg_index))
				CFG_CAL_LOW:  cal_lo_q  <= cfg_data;
				CFG_CAL_MID:  cal_mid_q <= cfg_data;
				CFG_CAL_HIGH: cal_hi_q  <= cfg_data[31:0];
				CFG_FSEL:     fsel_q    <= cfg_data[7:0];
				CFG_VERSION:  ver_q     <= cfg_data[4:0];
				CFG_CORR_EN:  cen_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Coefficients follow the configuration directly; the user must change it only while idle (not enforced here).
	logic [31:0] w [10];
	logic signed [31:0] c0, c1k, c2m, c3, c4k, c5k, c6, k7s, c8k, c9, c10, c11, c12, dpc2;
	logic signed [31:0] c5;

	always_comb begin
		logic two;
		logic [31:0] c4, c7, c12u;
		logic signed [31:0] dmul;
		for (int i = 0; i < 4; i++) begin
			w[i]   = {16'd0, cal_lo_q[63-16*i -: 16]};
			w[i+4] = {16'd0, cal_mid_q[63-16*i -: 16]};
		end
		w[8] = {16'd0, cal_hi_q[31:16]};
		w[9] = {16'd0, cal_hi_q[15:0]};
		two = (fsel_q[7:4] == 4'h1) || (fsel_q[3:0] == 4'h1);
		c0  = $signed(w[0] >> 4);
		c3  = $signed(w[2] >> 3);
		c5  = $signed(w[4] >> 1);
		c6  = $signed(w[5] >> 3);
		c9  = $signed(w[8] >> 2);
		c10 = $signed(((w[9] & 32'hFF00) >> 6) | (w[8] & 32'h3));
		c11 = $signed(w[9] & 32'hFF);
		c1k = $signed(((w[1] & 32'hFF00) >> 5) | (w[2] & 32'h7));
		c2m = $signed(((w[1] & 32'hFF) << 1) | (w[4] & 32'h1)) - 32'sd256;
		if (two) begin
			c4   = (w[3] << 2) | (w[0] & 32'h3);
			c7   = (w[6] << 3) | (w[5] & 32'h7);
			c12u = ((w[0] & 32'hC) << 1) | (w[7] & 32'h7);
			c1k  = c1k + K1_TWO;
			c4k  = ($signed(c4) + K4_TWO) <<< 4;
			c5k  = c5 - K5_TWO;
			k7s  = $signed(c7) + K7_TWO;
			c8k  = $signed(w[7] >> 3) + K8_TWO;
		end else begin
			c4   = (w[3] << 1) | (w[5] & 32'h1);
			c7   = (w[6] << 2) | ((w[0] >> 2) & 32'h3);
			c12u = ((w[5] & 32'h6) << 2) | (w[7] & 32'h7);
			c1k  = c1k + K1_ONE;
			c4k  = ($signed(c4) + K4_ONE) <<< 4;
			c5k  = c5;
			k7s  = $signed(c7) + K7_ONE;
			c8k  = $signed(w[7] >> 3) + K8_ONE;
		end
		c12  = $signed(c12u);
		dmul = 32'sd549 * (c5 - 32'sd16384);
		dpc2 = ((dmul >>> 9) + 32'sd559) >>> 4;
	end

	// Pipeline control: every stage moves together unless the output word is stalled.
	logic [20:1] v;
	logic adv;
	assign adv       = !v[20] || out_ready;
	assign in_ready  = adv;
	assign out_valid = v[20];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else if (adv) begin
			v <= {v[19:1], in_valid};
		end
	end

	logic signed [31:0] dt_s1, up_s1;
	logic signed [31:0] m1_s2, m2_s2, m3_s2, dt_s2, up_s2;
	logic signed [31:0] x01_s3, a2_s3, a3_s3, dt_s3, up_s3;
	logic signed [31:0] x01_s4, x02_s4, b3_s4, up_s4;
	logic signed [31:0] rt_s5, dt2_s5, up_s5;
	logic signed [31:0] x11_s6, e6_s6, x21m_s6, e9_s6, cfm_s6, dt2_s6, rt_s6, drt_s6;
	logic signed [31:0] la_s6, lb_s6, up_s6;
	logic signed [31:0] x11_s7, x12p_s7, x21_s7, x22p_s7, cf_s7, ca_s7, drt_s7, dp_s7;
	logic signed [31:0] rt_s7, up_s7;
	logic signed [31:0] x13_s8, x23_s8, cfa_s8, cfb_s8, cb_s8, dp_s8, rt_s8, up_s8;
	logic               neg_s8;
	logic signed [31:0] x24_s9, x25m_s9, pp1_s9, f1_s9, f2_s9, cor_s9, dp_s9, rt_s9;
	logic               neg_s9;
	logic signed [31:0] x26_s10, pp1_s10, f1_s10, f2_s10, cor_s10, dp_s10, rt_s10;
	logic signed [31:0] pp2_s11, pp3m_s11, f1_s11, f2_s11, cor_s11, dp_s11, rt_s11;
	logic signed [31:0] pp4_s12, f1_s12, f2_s12, cor_s12, dp_s12, rt_s12;
	logic signed [31:0] x31m_s13, x32a_s13, pp4_s13, cor_s13, dp_s13, rt_s13;
	logic signed [31:0] x31_s14, x32b_s14, pp4_s14, cor_s14, dp_s14, rt_s14;
	logic signed [31:0] rp_s15, cor_s15, dp_s15, rt_s15;
	logic signed [31:0] rp_s16, rt_s16;
	logic [3:0]         seg_s17, seg_s18, seg_s19;
	logic signed [15:0] d_s17, d_s18;
	logic signed [31:0] rp_s17, rt_s17;
	logic signed [31:0] hm1_s18, hm2_s18, rp_s18, rt_s18;
	logic signed [31:0] hp1_s19, t_s19, rp_s19, rt_s19;
	logic signed [31:0] alt_s20, rp_s20, rt_s20;

	logic signed [31:0] ut_ext, up_ext, x22_c, x21_c, diff_c, x12_c, dp_c, rp_c, hp2_c;
	logic signed [31:0] x25_c, d32_c;
	logic [3:0] seg_c;

	always_comb begin
		ut_ext = $signed({8'd0, in_data.raw_temperature});
		up_ext = $signed({8'd0, in_data.raw_pressure});
		x21_c  = x21_s7;
		x22_c  = x22p_s7 >>> 12;
		diff_c = x22_c - x21_c;
		x12_c  = x12p_s7 >>> 2;
		dp_c   = (la_s6 >>> 16) + 32'sd46;
		if (rt_s6 < 32'sd700) begin
			dp_c = (lb_s6 >>> 16) - 32'sd9 + dp_c;
		end
		x25_c = x25m_s9 >>> 11;
		rp_c  = rp_s15;
		if (ver_q == VERSION_CORR) begin
			if (cen_q[0]) begin
				rp_c = rp_c - cor_s15;
			end
			if (cen_q[1] && (rt_s15 < 32'sd2000)) begin
				rp_c = rp_c - dp_s15;
			end
		end
		// Segment search: the first threshold the pressure is not below.
		seg_c = 4'd15;
		for (int i = 14; i >= 0; i--) begin
			if (!(rp_s16 < seg_thr(4'(i)))) begin
				seg_c = 4'(i);
			end
		end
		d32_c = rp_s16 - seg_base(seg_c);
		hp2_c = t_s19 >>> 4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dt_s1 <= ((ut_ext - RAW_OFFSET) >>> 4) + (c0 <<< 4);
			up_s1 <= up_ext;

			m1_s2 <= c1k * dt_s1;
			m2_s2 <= c2m * dt_s1;
			m3_s2 <= c3 * dt_s1;
			dt_s2 <= dt_s1;
			up_s2 <= up_s1;

			x01_s3 <= m1_s2 >>> 1;
			a2_s3  <= (m2_s2 >>> 14) * dt_s2;
			a3_s3  <= (m3_s2 >>> 18) * dt_s2;
			dt_s3  <= dt_s2;
			up_s3  <= up_s2;

			x01_s4 <= x01_s3;
			x02_s4 <= a2_s3 >>> 4;
			b3_s4  <= (a3_s3 >>> 18) * dt_s3;
			up_s4  <= up_s3;

			rt_s5  <= (T_BASE - x01_s4 - x02_s4 - b3_s4) >>> 15;
			dt2_s5 <= (x01_s4 + x02_s4 + b3_s4) >>> 12;
			up_s5  <= up_s4;

			x11_s6  <= c5k * dt2_s5;
			e6_s6   <= c6 * dt2_s5;
			x21m_s6 <= c8k * dt2_s5;
			e9_s6   <= c9 * dt2_s5;
			cfm_s6  <= c12 * dt2_s5;
			dt2_s6  <= dt2_s5;
			rt_s6   <= rt_s5;
			drt_s6  <= rt_s5 - 32'sd2500;
			la_s6   <= rt_s5 * (-32'sd1513);
			lb_s6   <= rt_s5 * 32'sd819;
			up_s6   <= up_s5;

			x11_s7  <= x11_s6;
			x12p_s7 <= (e6_s6 >>> 16) * dt2_s6;
			x21_s7  <= x21m_s6 >>> 10;
			x22p_s7 <= (e9_s6 >>> 17) * dt2_s6;
			cf_s7   <= (CF_BASE + cfm_s6) >>> 3;
			ca_s7   <= dpc2 * drt_s6;
			drt_s7  <= drt_s6;
			dp_s7   <= dp_c;
			rt_s7   <= rt_s6;
			up_s7   <= up_s6;

			x13_s8 <= ((x11_s7 + x12_c) >>> 10) + c4k;
			x23_s8 <= (x22_c >= x21_c) ? diff_c : (x21_c - x22_c);
			neg_s8 <= diff_c[31];
			cfa_s8 <= cf_s7 * c10;
			cfb_s8 <= cf_s7 * c11;
			cb_s8  <= (ca_s7 >>> 15) * drt_s7;
			dp_s8  <= dp_s7;
			rt_s8  <= rt_s7;
			up_s8  <= up_s7;

			x24_s9  <= (x23_s8 >>> 11) * k7s;
			x25m_s9 <= $signed(x23_s8 & LOW_MASK) * k7s;
			neg_s9  <= neg_s8;
			pp1_s9  <= (up_s8 - RAW_OFFSET - x13_s8) >>> 3;
			f1_s9   <= cfa_s8 >>> 17;
			f2_s9   <= cfb_s8 >>> 15;
			cor_s9  <= cb_s8 >>> 11;
			dp_s9   <= dp_s8;
			rt_s9   <= rt_s8;

			x26_s10 <= neg_s9 ? (((32'sd0 - x24_s9 - x25_c) >>> 11) + k7s)
			                  : (((x24_s9 + x25_c) >>> 11) + k7s);
			pp1_s10 <= pp1_s9;
			f1_s10  <= f1_s9;
			f2_s10  <= f2_s9;
			cor_s10 <= cor_s9;
			dp_s10  <= dp_s9;
			rt_s10  <= rt_s9;

			pp2_s11  <= (x26_s10 >>> 11) * pp1_s10;
			pp3m_s11 <= $signed(x26_s10 & LOW_MASK) * pp1_s10;
			f1_s11   <= f1_s10;
			f2_s11   <= f2_s10;
			cor_s11  <= cor_s10;
			dp_s11   <= dp_s10;
			rt_s11   <= rt_s10;

			pp4_s12 <= (pp2_s11 + (pp3m_s11 >>> 11)) >>> 10;
			f1_s12  <= f1_s11;
			f2_s12  <= f2_s11;
			cor_s12 <= cor_s11;
			dp_s12  <= dp_s11;
			rt_s12  <= rt_s11;

			x31m_s13 <= f1_s12 * pp4_s12;
			x32a_s13 <= f2_s12 * pp4_s12;
			pp4_s13  <= pp4_s12;
			cor_s13  <= cor_s12;
			dp_s13   <= dp_s12;
			rt_s13   <= rt_s12;

			x31_s14  <= x31m_s13 >>> 2;
			x32b_s14 <= (x32a_s13 >>> 18) * pp4_s13;
			pp4_s14  <= pp4_s13;
			cor_s14  <= cor_s13;
			dp_s14   <= dp_s13;
			rt_s14   <= rt_s13;

			rp_s15  <= ((x31_s14 + x32b_s14) >>> 15) + pp4_s14 + P_BASE;
			cor_s15 <= cor_s14;
			dp_s15  <= dp_s14;
			rt_s15  <= rt_s14;

			rp_s16 <= rp_c;
			rt_s16 <= rt_s15;

			// The pressure difference from the segment base keeps only its low 16 bits, taken as signed.
			seg_s17 <= seg_c;
			d_s17   <= d32_c[15:0];
			rp_s17  <= rp_s16;
			rt_s17  <= rt_s16;

			hm1_s18 <= seg_hs0(seg_s17) * d_s17;
			hm2_s18 <= seg_hs1(seg_s17) * d_s17;
			seg_s18 <= seg_s17;
			d_s18   <= d_s17;
			rp_s18  <= rp_s17;
			rt_s18  <= rt_s17;

			hp1_s19 <= hm1_s18 >>> 2;
			t_s19   <= (hm2_s18 >>> 10) * d_s18;
			seg_s19 <= seg_s18;
			rp_s19  <= rp_s18;
			rt_s19  <= rt_s18;

			alt_s20 <= ((seg_h0(seg_s19) <<< 6) + hp1_s19 + hp2_c) >>> 6;
			rp_s20  <= rp_s19;
			rt_s20  <= rt_s19;
		end
	end

	assign out_data.temperature_centi = rt_s20;
	assign out_data.pressure_pa       = rp_s20;
	assign out_data.altitude_mm       = alt_s20;

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v[1])
		else $error("accepted word did not enter the first stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(v))
		else $error("pipeline moved while the output word was stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v[19] && adv |=> out_valid)
		else $error("word lost in the last stage");

endmodule

@@ sim/tb_baro_pressure_temp_compensation_top.sv @@
`timescale 1ns / 1ps

module tb_baro_pressure_temp_compensation_top;
	import bpc_pkg::*;

	localparam int PIPE_DEPTH = 20;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	bpc_in_t in_data;
	logic out_valid;
	logic out_ready;
	bpc_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	baro_pressure_temp_compensation_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the configuration registers.
	logic [63:0] cal_low;
	logic [63:0] cal_mid;
	logic [31:0] cal_high;
	logic [7:0] fsel;
	logic [4:0] chip_ver;
	logic [1:0] corr_en;

	bpc_in_t pending_words[$];
	bpc_out_t expected_results[$];
	int error_count;
	int cycle_count;
	bit idle_enable;
	bit hold_output;
	int send_gap;
	int recv_gap;

	function automatic logic [31:0] asr(input logic [31:0] v, input int n);
		return $unsigned($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] altitude_of(input logic [31:0] p);
		logic [31:0] d;
		logic [31:0] hp1;
		logic [31:0] hp2;
		int i;
		i = 0;
		while (i < 15 && $signed(p) < seg_thr(i[3:0]))
			i++;
		d = p - $unsigned(seg_base(i[3:0]));
		d = {{16{d[15]}}, d[15:0]};
		hp1 = asr($unsigned(seg_hs0(i[3:0])) * d, 2);
		hp2 = asr(asr($unsigned(seg_hs1(i[3:0])) * d, 10) * d, 4);
		return asr(($unsigned(seg_h0(i[3:0])) << 6) + hp1 + hp2, 6);
	endfunction

	function automatic bpc_out_t compensate(input bpc_in_t x);
		logic [15:0] w[10];
		logic [31:0] c0, c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11, c12;
		logic [31:0] k1, k4, k5, k7, k8;
		logic [31:0] dt, x01, x02, x03, rt, dt2, x11, x12, x13;
		logic [31:0] x21, x22, x23, x24, x25, x26, pp1, pp2, pp3, pp4, cf, x31, x32, rp;
		logic [31:0] dc5, drt, dpc2, dp;
		bit two;
		bpc_out_t r;
		for (int i = 0; i < 4; i++) begin
			w[i] = cal_low[63 - 16 * i -: 16];
			w[i + 4] = cal_mid[63 - 16 * i -: 16];
		end
		w[8] = cal_high[31:16];
		w[9] = cal_high[15:0];
		two = (fsel[7:4] == 4'h1) || (fsel[3:0] == 4'h1);
		c0 = 32'(w[0] >> 4);
		c1 = 32'((w[1] & 16'hFF00) >> 5) | 32'(w[2] & 16'h7);
		c2 = (32'(w[1] & 16'hFF) << 1) | 32'(w[4] & 16'h1);
		c3 = 32'(w[2] >> 3);
		c5 = 32'(w[4] >> 1);
		c6 = 32'(w[5] >> 3);
		c8 = 32'(w[7] >> 3);
		c9 = 32'(w[8] >> 2);
		c10 = 32'((w[9] & 16'hFF00) >> 6) | 32'(w[8] & 16'h3);
		c11 = 32'(w[9] & 16'hFF);
		if (two) begin
			c4 = (32'(w[3]) << 2) | 32'(w[0] & 16'h3);
			c7 = (32'(w[6]) << 3) | 32'(w[5] & 16'h7);
			c12 = (32'(w[0] & 16'hC) << 1) | 32'(w[7] & 16'h7);
			k1 = K1_TWO; k4 = K4_TWO; k5 = K5_TWO; k7 = K7_TWO; k8 = K8_TWO;
		end else begin
			c4 = (32'(w[3]) << 1) | 32'(w[5] & 16'h1);
			c7 = (32'(w[6]) << 2) | 32'((w[0] >> 2) & 16'h3);
			c12 = (32'(w[5] & 16'h6) << 2) | 32'(w[7] & 16'h7);
			k1 = K1_ONE; k4 = K4_ONE; k5 = 32'd0; k7 = K7_ONE; k8 = K8_ONE;
		end
		dt = asr(32'(x.raw_temperature) - RAW_OFFSET, 4) + (c0 << 4);
		x01 = asr((c1 + k1) * dt, 1);
		x02 = asr(asr((c2 - 32'd256) * dt, 14) * dt, 4);
		x03 = asr(asr(c3 * dt, 18) * dt, 18) * dt;
		rt = asr(T_BASE - x01 - x02 - x03, 15);
		dt2 = asr(x01 + x02 + x03, 12);
		x11 = (c5 - k5) * dt2;
		x12 = asr(asr(c6 * dt2, 16) * dt2, 2);
		x13 = asr(x11 + x12, 10) + ((c4 + k4) << 4);
		x21 = asr((c8 + k8) * dt2, 10);
		x22 = asr(asr(c9 * dt2, 17) * dt2, 12);
		x23 = ($signed(x22) >= $signed(x21)) ? x22 - x21 : x21 - x22;
		k7 = c7 + k7;
		x24 = asr(x23, 11) * k7;
		x25 = asr((x23 & LOW_MASK) * k7, 11);
		if ($signed(x22 - x21) < 0)
			x26 = asr(32'd0 - x24 - x25, 11) + k7;
		else
			x26 = asr(x24 + x25, 11) + k7;
		pp1 = asr(32'(x.raw_pressure) - RAW_OFFSET - x13, 3);
		pp2 = asr(x26, 11) * pp1;
		pp3 = asr((x26 & LOW_MASK) * pp1, 11);
		pp4 = asr(pp2 + pp3, 10);
		cf = asr(CF_BASE + c12 * dt2, 3);
		x31 = asr(asr(cf * c10, 17) * pp4, 2);
		x32 = asr(asr(cf * c11, 15) * pp4, 18) * pp4;
		rp = asr(x31 + x32, 15) + pp4 + P_BASE;
		if (chip_ver == VERSION_CORR) begin
			if (corr_en[0]) begin
				dc5 = c5 - 32'd16384;
				drt = rt - 32'd2500;
				dpc2 = asr(asr(32'd549 * dc5, 9) + 32'd559, 4);
				rp = rp - asr(asr(dpc2 * drt, 15) * drt, 11);
			end
			if (corr_en[1] && $signed(rt) < 2000) begin
				dp = asr(rt * 32'hFFFF_FA17, 16) + 32'd46;
				if ($signed(rt) < 700)
					dp = asr(rt * 32'd819, 16) + 32'hFFFF_FFF7 + dp;
				rp = rp - dp;
			end
		end
		r.temperature_centi = rt;
		r.pressure_pa = rp;
		r.altitude_mm = altitude_of(rp);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
		error_count++;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sender: takes words from the pending queue and predicts each one on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(compensate(in_data));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_words.pop_front();
					if (idle_enable && $urandom_range(0, 9) == 0)
						send_gap <= $urandom_range(1, 16);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver and checker.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("unexpected result word");
					error_count++;
				end else begin
					bpc_out_t e;
					e = expected_results.pop_front();
					if (out_data.temperature_centi !== e.temperature_centi)
						report_mismatch("temperature", out_data.temperature_centi,
							e.temperature_centi);
					if (out_data.pressure_pa !== e.pressure_pa)
						report_mismatch("pressure", out_data.pressure_pa, e.pressure_pa);
					if (out_data.altitude_mm !== e.altitude_mm)
						report_mismatch("altitude", out_data.altitude_mm, e.altitude_mm);
				end
			end
			if (hold_output) begin
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idle_enable && $urandom_range(0, 9) == 0)
					recv_gap <= $urandom_range(1, 16);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(input bpc_cfg_idx_t idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CAL_LOW:  cal_low = value;
			CFG_CAL_MID:  cal_mid = value;
			CFG_CAL_HIGH: cal_high = value[31:0];
			CFG_FSEL:     fsel = value[7:0];
			CFG_VERSION:  chip_ver = value[4:0];
			CFG_CORR_EN:  corr_en = value[1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	function automatic bpc_in_t random_word();
		bpc_in_t x;
		case ($urandom_range(0, 3))
			0: begin
				x.raw_temperature = 24'($urandom);
				x.raw_pressure = 24'($urandom);
			end
			default: begin
				// Plausible readings around the midpoint reach the normal pressure range.
				x.raw_temperature = 24'(32'd8388608 + $urandom_range(0, 2000000) - 1000000);
				x.raw_pressure = 24'(32'd8388608 + $urandom_range(0, 4000000) - 2000000);
			end
		endcase
		return x;
	endfunction

	// Calibration words by kind: all zeros, all ones, or fully random.
	task automatic random_calibration(input int kind);
		logic [63:0] lo, mi, hi;
		if (kind == 0) begin
			lo = '0; mi = '0; hi = '0;
		end else if (kind == 1) begin
			lo = '1; mi = '1; hi = 64'hFFFF_FFFF;
		end else begin
			lo = {$urandom, $urandom};
			mi = {$urandom, $urandom};
			hi = {32'd0, $urandom};
		end
		write_reg(CFG_CAL_LOW, lo);
		write_reg(CFG_CAL_MID, mi);
		write_reg(CFG_CAL_HIGH, hi);
	endtask

	initial begin
		bpc_in_t x;
		idle_enable = 1'b1;
		hold_output = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CAL_LOW;
		cfg_data = '0;
		cal_low = '0; cal_mid = '0; cal_high = '0;
		fsel = 8'd1; chip_ver = 5'd0; corr_en = 2'd3;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at reset configuration: field extremes, values at the midpoint and 0x555555.
		for (int t = 0; t < 4; t++)
			for (int p = 0; p < 4; p++) begin
				x.raw_temperature = (t == 0) ? 24'h0 : (t == 1) ? 24'hFFFFFF :
					(t == 2) ? 24'h800000 : 24'h7FFFFF;
				x.raw_pressure = (p == 0) ? 24'h0 : (p == 1) ? 24'hFFFFFF :
					(p == 2) ? 24'h800000 : 24'h555555;
				pending_words.push_back(x);
			end
		drain();

		// Phases sweep calibration, both formulas and the correction settings.
		for (int ph = 0; ph < 12; ph++) begin
			random_calibration(ph < 2 ? ph : 2);
			case (ph % 4)
				0: write_reg(CFG_FSEL, 64'h01);
				1: write_reg(CFG_FSEL, 64'hFF);
				2: write_reg(CFG_FSEL, 64'h10);
				default: write_reg(CFG_FSEL, 64'($urandom_range(0, 255)));
			endcase
			write_reg(CFG_VERSION, (ph % 3 == 2) ? 64'd31 : (ph % 3 == 1) ? 64'd0 : 64'd3);
			write_reg(CFG_CORR_EN, 64'(ph % 4));
			if (ph == 11)
				idle_enable = 1'b0;
			for (int n = 0; n < 100; n++)
				pending_words.push_back(random_word());
			if (ph == 5) begin
				hold_output = 1'b1;
				repeat (200) @(posedge clk);
				hold_output = 1'b0;
			end
			drain();
		end

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/bpc_pkg.sv
hw/rtl/baro_pressure_temp_compensation_top.sv
sim/tb_baro_pressure_temp_compensation_top.sv
